// ----- hw/rtl/uart_frame_line_encoder_core_assert.svh -----
// Assertion macros used by the checker file.
`ifndef UART_FRAME_LINE_ENCODER_CORE_ASSERT_SVH
`define UART_FRAME_LINE_ENCODER_CORE_ASSERT_SVH

// Checked at every rising clock edge outside reset.
`define UFLE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every rising clock edge, also while reset is applied.
`define UFLE_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ----- hw/rtl/ufle_pkg.sv -----
`default_nettype none

package ufle_pkg;

  localparam int unsigned TickW  = 16;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned BitIdxW = 3;

  localparam logic LvlLow  = 1'b0;
  localparam logic LvlHigh = 1'b1;

  // Register indexes of the configuration port
  localparam int unsigned CfgIdxW = 2;
  typedef enum logic [CfgIdxW-1:0] {
    CfgLineCode   = 2'd0,
    CfgBitTime    = 2'd1,
    CfgFirstHalf  = 2'd2,
    CfgSecondHalf = 2'd3
  } cfg_idx_e;

  // Reset values of the registers
  localparam logic             RstLineCode   = 1'b0;
  localparam logic [TickW-1:0] RstBitTime    = 16'd1000;
  localparam logic [TickW-1:0] RstFirstHalf  = 16'd500;
  localparam logic [TickW-1:0] RstSecondHalf = 16'd500;

  // One classified byte, handed from the front to the back
  typedef struct packed {
    logic [ByteW-1:0] data;
    logic             last;
    logic             start;
    logic             manch;
  } ufle_cmd_t;

  // Durations used by the back
  typedef struct packed {
    logic [TickW-1:0] bit_time;
    logic [TickW-1:0] first_half;
    logic [TickW-1:0] second_half;
  } ufle_timing_t;

  // Sequencer phases, one-hot
  typedef enum logic [3:0] {
    PhStart = 4'b0001,
    PhData  = 4'b0010,
    PhStop1 = 4'b0100,
    PhStop2 = 4'b1000
  } ufle_phase_e;

endpackage

`default_nettype wire

// ----- hw/rtl/uart_frame_line_encoder_core.sv -----
// Channel  | Direction | Handshake                    | Payload
// ---------+-----------+------------------------------+-------------------------------------
// in       | input     | in_valid_i / in_ready_o      | data_byte_i, last_byte_i
// out      | output    | out_valid_o / out_ready_i    | line_level_o, chip_ticks_o,
//          |           |                              | run_end_o, frame_end_o
// cfg      | input     | cfg_we_i (no wait)           | cfg_idx_i, cfg_wdata_i
//
// Each byte yields 8 to 19 chips (19 with start, Manchester data and stop), one
// per cycle from the back sequencer while the output is not stalled. An accepted byte is
// registered into the queue; its first chip is formed from the back's command register
// once the back picks it up, then held in the output register. The input stays ready
// while the QueueDepth-entry queue has room. Reset (rst_ni, async low) closes any frame
// and restores register defaults. A stalled output holds its chip and the sequencer.
`default_nettype none

module uart_frame_line_encoder_core import ufle_pkg::*; #(
  parameter int unsigned QueueDepth = 2
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [ByteW-1:0]   data_byte_i,
  input  wire logic               last_byte_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic                    line_level_o,
  output logic [TickW-1:0]        chip_ticks_o,
  output logic                    run_end_o,
  output logic                    frame_end_o,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [TickW-1:0]   cfg_wdata_i
);

  logic         line_code_q;
  ufle_timing_t timing_q;

  logic         push, full, pop, empty;
  ufle_cmd_t    push_cmd, pop_cmd;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_code_q          <= RstLineCode;
      timing_q.bit_time    <= RstBitTime;
      timing_q.first_half  <= RstFirstHalf;
      timing_q.second_half <= RstSecondHalf;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgLineCode:   line_code_q          <= cfg_wdata_i[0];
        CfgBitTime:    timing_q.bit_time    <= cfg_wdata_i;
        CfgFirstHalf:  timing_q.first_half  <= cfg_wdata_i;
        CfgSecondHalf: timing_q.second_half <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  ufle_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .data_byte_i (data_byte_i),
    .last_byte_i (last_byte_i),
    .line_code_i (line_code_q),
    .push_o      (push),
    .cmd_o       (push_cmd),
    .full_i      (full)
  );

  ufle_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_cmd),
    .full_o  (full),
    .pop_i   (pop),
    .rdata_o (pop_cmd),
    .empty_o (empty)
  );

  ufle_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (pop_cmd),
    .empty_i      (empty),
    .pop_o        (pop),
    .timing_i     (timing_q),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .line_level_o (line_level_o),
    .chip_ticks_o (chip_ticks_o),
    .run_end_o    (run_end_o),
    .frame_end_o  (frame_end_o)
  );

endmodule

`default_nettype wire

// ----- hw/rtl/ufle_fifo.sv -----
`default_nettype none

module ufle_fifo import ufle_pkg::*; #(
  parameter int unsigned Depth = 2
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      push_i,
  input  wire ufle_cmd_t wdata_i,
  output logic           full_o,
  input  wire logic      pop_i,
  output ufle_cmd_t      rdata_o,
  output logic           empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  ufle_cmd_t         mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  // Advance pointers with wrap at the depth
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store the entry
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/ufle_front.sv -----
`default_nettype none

module ufle_front import ufle_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic [ByteW-1:0] data_byte_i,
  input  wire logic             last_byte_i,
  input  wire logic             line_code_i,
  output logic                  push_o,
  output ufle_cmd_t             cmd_o,
  input  wire logic             full_i
);

  logic in_frame_q, in_frame_d;
  logic accept;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && !full_i;
  assign push_o     = accept;

  // Classify the beat: start chip needed when no frame is open
  always_comb begin
    cmd_o.data  = data_byte_i;
    cmd_o.last  = last_byte_i;
    cmd_o.start = !in_frame_q;
    cmd_o.manch = line_code_i;
  end

  // Open a frame on every beat, close it on the last byte
  assign in_frame_d = accept ? !last_byte_i : in_frame_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q <= 1'b0;
    end else begin
      in_frame_q <= in_frame_d;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/ufle_back.sv -----
`default_nettype none

module ufle_back import ufle_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire ufle_cmd_t        cmd_i,
  input  wire logic             empty_i,
  output logic                  pop_o,
  input  wire ufle_timing_t     timing_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output logic                  line_level_o,
  output logic [TickW-1:0]      chip_ticks_o,
  output logic                  run_end_o,
  output logic                  frame_end_o
);

  logic               busy_q, busy_d;
  ufle_cmd_t          cmd_q, cmd_d;
  ufle_phase_e        phase_q, phase_d;
  logic [BitIdxW-1:0] bit_q, bit_d;
  logic               half_q, half_d;

  logic               out_valid_q, out_valid_d;
  logic               level_q, level_d;
  logic [TickW-1:0]   ticks_q, ticks_d;
  logic               run_end_q, run_end_d;
  logic               frame_end_q, frame_end_d;

  logic               advance, load, cur_bit, data_done;

  assign advance   = busy_q && (!out_valid_q || out_ready_i);
  assign cur_bit   = cmd_q.data[bit_q];
  assign data_done = (bit_q == BitIdxW'(ByteW - 1)) && (!cmd_q.manch || half_q);

  // Form the current chip
  always_comb begin
    level_d     = LvlHigh;
    ticks_d     = timing_i.bit_time;
    run_end_d   = 1'b0;
    frame_end_d = 1'b0;
    unique case (phase_q)
      PhStart: begin
        level_d = LvlLow;
      end
      PhData: begin
        if (cmd_q.manch) begin
          level_d = half_q ? cur_bit : !cur_bit;
          ticks_d = half_q ? timing_i.second_half : timing_i.first_half;
        end else begin
          level_d = cur_bit;
        end
        run_end_d = data_done && !cmd_q.last;
      end
      PhStop1: begin
        level_d = LvlHigh;
      end
      PhStop2: begin
        run_end_d   = 1'b1;
        frame_end_d = 1'b1;
      end
      default: begin
        level_d = LvlHigh;
      end
    endcase
  end

  // Take the next command when idle or when the current byte finishes
  assign load  = !busy_q || (advance && run_end_d);
  assign pop_o = load && !empty_i;

  // Step through start, data bits and halves, stop chips
  always_comb begin
    busy_d  = busy_q;
    cmd_d   = cmd_q;
    phase_d = phase_q;
    bit_d   = bit_q;
    half_d  = half_q;
    if (load) begin
      busy_d  = !empty_i;
      cmd_d   = cmd_i;
      phase_d = cmd_i.start ? PhStart : PhData;
      bit_d   = '0;
      half_d  = 1'b0;
    end else if (advance) begin
      unique case (phase_q)
        PhStart: begin
          phase_d = PhData;
        end
        PhData: begin
          if (data_done) begin
            phase_d = PhStop1;
          end else if (cmd_q.manch && !half_q) begin
            half_d = 1'b1;
          end else begin
            half_d = 1'b0;
            bit_d  = bit_q + 1'b1;
          end
        end
        PhStop1: begin
          phase_d = PhStop2;
        end
        default: begin
          phase_d = PhStart;
        end
      endcase
    end
  end

  // Output register: refill on advance, drop when taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      phase_q     <= PhStart;
      bit_q       <= '0;
      half_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      phase_q     <= phase_d;
      bit_q       <= bit_d;
      half_q      <= half_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Hold payload until the next chip is formed
  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    if (advance) begin
      level_q     <= level_d;
      ticks_q     <= ticks_d;
      run_end_q   <= run_end_d;
      frame_end_q <= frame_end_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign line_level_o = level_q;
  assign chip_ticks_o = ticks_q;
  assign run_end_o    = run_end_q;
  assign frame_end_o  = frame_end_q;

endmodule

`default_nettype wire

// ----- hw/rtl/ufle_checker.sv -----
`default_nettype none

`include "uart_frame_line_encoder_core_assert.svh"

module ufle_checker import ufle_pkg::*; (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid_i,
  input wire logic               in_ready_o,
  input wire logic [ByteW-1:0]   data_byte_i,
  input wire logic               last_byte_i,
  input wire logic               out_valid_o,
  input wire logic               out_ready_i,
  input wire logic               line_level_o,
  input wire logic [TickW-1:0]   chip_ticks_o,
  input wire logic               run_end_o,
  input wire logic               frame_end_o,
  input wire logic               cfg_we_i,
  input wire logic [CfgIdxW-1:0] cfg_idx_i,
  input wire logic [TickW-1:0]   cfg_wdata_i
);

  // No chip is offered while reset is applied
  `UFLE_ASSERT_ALWAYS(a_no_out_in_reset, !rst_ni |-> !out_valid_o, "chip valid in reset")

  // A stalled chip keeps its level, duration and flags
  `UFLE_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(line_level_o) && $stable(chip_ticks_o) && $stable(run_end_o) && $stable(frame_end_o), "stalled chip changed")

  // The frame closes only on a high chip that also ends its byte
  `UFLE_ASSERT(a_frame_end_run_end, out_valid_o && frame_end_o |-> run_end_o && line_level_o, "frame end not on last high chip")

  // The closing chip follows a high stop chip, or itself while stalled
  `UFLE_ASSERT(a_stop_pair, out_valid_o && out_ready_i && frame_end_o |-> $past(line_level_o) && ($past(frame_end_o) || !$past(run_end_o)), "second stop chip without first")

endmodule

bind uart_frame_line_encoder_core ufle_checker u_ufle_checker (.*);

`default_nettype wire

// ----- tb/ufle_chip_checker.sv -----
module ufle_chip_checker import ufle_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic [ByteW-1:0]   data_byte_i,
  input  logic               last_byte_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic               line_level_i,
  input  logic [TickW-1:0]   chip_ticks_i,
  input  logic               run_end_i,
  input  logic               frame_end_i,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [TickW-1:0]   cfg_wdata_i,
  output int                 fail_count_o,
  output int                 pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic             level;
    logic [TickW-1:0] ticks;
    logic             run_end;
    logic             frame_end;
  } line_chip_t;

  // Register copies and frame state
  logic             manchester;
  logic [TickW-1:0] bit_ticks;
  logic [TickW-1:0] first_ticks;
  logic [TickW-1:0] second_ticks;
  logic             frame_open;

  line_chip_t chip_q[$];

  function automatic void push_chip(input logic lvl, input logic [TickW-1:0] ticks,
                                    input logic run_last, input logic frame_last);
    line_chip_t c;
    c.level     = lvl;
    c.ticks     = ticks;
    c.run_end   = run_last;
    c.frame_end = frame_last;
    chip_q.push_back(c);
  endfunction

  // Expand one byte into its chips: optional start, data LSB first, optional stops
  function automatic void encode_byte(input logic [ByteW-1:0] b, input logic last);
    if (!frame_open) begin
      push_chip(LvlLow, bit_ticks, 1'b0, 1'b0);
      frame_open = 1'b1;
    end
    for (int i = 0; i < ByteW; i++) begin
      if (manchester) begin
        if (b[i]) begin
          push_chip(LvlLow, first_ticks, 1'b0, 1'b0);
          push_chip(LvlHigh, second_ticks, (i == ByteW - 1) && !last, 1'b0);
        end else begin
          push_chip(LvlHigh, first_ticks, 1'b0, 1'b0);
          push_chip(LvlLow, second_ticks, (i == ByteW - 1) && !last, 1'b0);
        end
      end else begin
        push_chip(b[i], bit_ticks, (i == ByteW - 1) && !last, 1'b0);
      end
    end
    if (last) begin
      push_chip(LvlHigh, bit_ticks, 1'b0, 1'b0);
      push_chip(LvlHigh, bit_ticks, 1'b1, 1'b1);
      frame_open = 1'b0;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    line_chip_t want;
    if (!rst_ni) begin
      manchester   = RstLineCode;
      bit_ticks    = RstBitTime;
      first_ticks  = RstFirstHalf;
      second_ticks = RstSecondHalf;
      frame_open   = 1'b0;
      chip_q.delete();
      fail_count_o = 0;
    end else begin
      // Compare an output beat against the oldest expected chip
      if (out_valid_i && out_ready_i) begin
        if (chip_q.size() == 0) begin
          $error("unexpected chip: line_level %0d chip_ticks %0d", line_level_i,
                 chip_ticks_i);
          fail_count_o++;
        end else begin
          want = chip_q.pop_front();
          if (line_level_i !== want.level) begin
            $error("line_level: expected %0d, got %0d", want.level, line_level_i);
            fail_count_o++;
          end
          if (chip_ticks_i !== want.ticks) begin
            $error("chip_ticks: expected %0d, got %0d", want.ticks, chip_ticks_i);
            fail_count_o++;
          end
          if (run_end_i !== want.run_end) begin
            $error("run_end: expected %0d, got %0d", want.run_end, run_end_i);
            fail_count_o++;
          end
          if (frame_end_i !== want.frame_end) begin
            $error("frame_end: expected %0d, got %0d", want.frame_end, frame_end_i);
            fail_count_o++;
          end
        end
      end
      // Track register writes
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CfgLineCode:   manchester   = cfg_wdata_i[0];
          CfgBitTime:    bit_ticks    = cfg_wdata_i;
          CfgFirstHalf:  first_ticks  = cfg_wdata_i;
          CfgSecondHalf: second_ticks = cfg_wdata_i;
          default: ;
        endcase
      end
      // Predict the chips of an accepted input beat
      if (in_valid_i && in_ready_i) begin
        encode_byte(data_byte_i, last_byte_i);
      end
    end
    pending_o = chip_q.size();
  end

endmodule

// ----- tb/tb_uart_frame_line_encoder_core.sv -----
module tb_uart_frame_line_encoder_core;
  import ufle_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NumPhases     = 12;
  localparam int BytesPerPhase = 37;
  localparam int HoldOffCycles = 300;
  localparam int SettleCycles  = 40;
  localparam int CycleLimit    = 5000000;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [ByteW-1:0]   data_byte_i;
  logic               last_byte_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic               line_level_o;
  logic [TickW-1:0]   chip_ticks_o;
  logic               run_end_o;
  logic               frame_end_o;
  logic               cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [TickW-1:0]   cfg_wdata_i;

  int   fail_count;
  int   chips_pending;
  int   cycles;
  logic calm;
  logic hold_off_req;

  uart_frame_line_encoder_core dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .data_byte_i  (data_byte_i),
    .last_byte_i  (last_byte_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .line_level_o (line_level_o),
    .chip_ticks_o (chip_ticks_o),
    .run_end_o    (run_end_o),
    .frame_end_o  (frame_end_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  ufle_chip_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .data_byte_i  (data_byte_i),
    .last_byte_i  (last_byte_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .line_level_i (line_level_o),
    .chip_ticks_i (chip_ticks_o),
    .run_end_i    (run_end_o),
    .frame_end_i  (frame_end_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .fail_count_o (fail_count),
    .pending_o    (chips_pending)
  );

  always #5 clk_i = ~clk_i;

  // Idle length: mostly none or short, now and then long, none while calm
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (calm) return 0;
    if (r < 65) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Durations: extremes now and then, zero included
  function automatic logic [TickW-1:0] rand_ticks();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return 16'd1;
    if (r == 2) return 16'hFFFF;
    return TickW'($urandom_range(1, 65535));
  endfunction

  function automatic logic [ByteW-1:0] rand_byte();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hFF;
    return ByteW'($urandom);
  endfunction

  // Called at a falling edge; returns at the falling edge after the beat
  task automatic send_byte(input logic [ByteW-1:0] b, input logic last);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= b;
    last_byte_i <= last;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [TickW-1:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Hold the input idle until every expected chip has come out
  task automatic drain();
    in_valid_i <= 1'b0;
    wait (chips_pending == 0);
    @(negedge clk_i);
  endtask

  task automatic settle();
    drain();
    repeat (4) @(negedge clk_i);
  endtask

  // Toggle between stretches with and without idling
  initial begin
    calm = 1'b0;
    forever begin
      repeat ($urandom_range(150, 500)) @(posedge clk_i);
      calm = ~calm;
    end
  end

  // Output side: random stalls, plus one long hold-off on request
  initial begin : receiver
    int stall;
    stall        = 0;
    out_ready_i  = 1'b0;
    hold_off_req = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ready_i <= 1'b0;
        repeat (HoldOffCycles) @(negedge clk_i);
      end else if (stall > 0) begin
        out_ready_i <= 1'b0;
        stall--;
      end else begin
        stall = gap_len();
        out_ready_i <= (stall == 0);
        if (stall > 0) stall--;
      end
    end
  end

  // Watchdog
  initial begin
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("uart_frame_line_encoder_core: mismatch");
    $finish;
  end

  initial begin : stimulus
    int               sent;
    int               flen;
    logic [ByteW-1:0] b;
    logic             last;
    logic [TickW-1:0] t_bit;
    logic [TickW-1:0] t_first;
    logic [TickW-1:0] t_second;

    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    data_byte_i = '0;
    last_byte_i = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = CfgLineCode;
    cfg_wdata_i = '0;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset defaults, NRZ: one-byte frames and a multi-byte frame
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_byte(8'hA5, 1'b0);
    send_byte(8'h5A, 1'b0);
    send_byte(8'h01, 1'b1);

    // Manchester with the shortest and longest halves; upper data bits masked
    settle();
    write_reg(CfgLineCode, 16'hFFFF);
    write_reg(CfgFirstHalf, 16'd1);
    write_reg(CfgSecondHalf, 16'hFFFF);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h3C, 1'b1);
    send_byte(8'h81, 1'b1);

    // Zero durations pass straight through
    settle();
    write_reg(CfgBitTime, 16'd0);
    write_reg(CfgFirstHalf, 16'd0);
    write_reg(CfgSecondHalf, 16'd0);
    write_reg(CfgLineCode, 16'h0002);
    send_byte(8'h55, 1'b1);
    send_byte(8'hAA, 1'b0);
    send_byte(8'h0F, 1'b1);
    settle();
    write_reg(CfgLineCode, 16'h0001);
    send_byte(8'hF0, 1'b1);

    // Switch the line code in the middle of an open frame
    settle();
    write_reg(CfgLineCode, 16'h0000);
    write_reg(CfgBitTime, 16'hFFFF);
    write_reg(CfgFirstHalf, 16'd7);
    write_reg(CfgSecondHalf, 16'd9);
    send_byte(8'h12, 1'b0);
    settle();
    write_reg(CfgLineCode, 16'h0001);
    send_byte(8'h34, 1'b0);
    settle();
    write_reg(CfgLineCode, 16'h0000);
    send_byte(8'h56, 1'b1);

    // Random phases: mostly well-formed frames, some stray last flags
    for (int p = 0; p < NumPhases; p++) begin
      settle();
      if (p == 0) begin
        t_bit    = 16'hFFFF;
        t_first  = 16'hFFFF;
        t_second = 16'hFFFF;
      end else if (p == 1) begin
        t_bit    = 16'd1;
        t_first  = 16'd1;
        t_second = 16'd1;
      end else begin
        t_bit    = rand_ticks();
        t_first  = rand_ticks();
        t_second = rand_ticks();
      end
      write_reg(CfgLineCode, {15'($urandom), 1'(p)});
      write_reg(CfgBitTime, t_bit);
      write_reg(CfgFirstHalf, t_first);
      write_reg(CfgSecondHalf, t_second);
      // Stall the output long enough for the input to back up
      if (p == 2) hold_off_req = 1'b1;
      sent = 0;
      while (sent < BytesPerPhase) begin
        flen = $urandom_range(1, 6);
        for (int k = 0; k < flen; k++) begin
          b    = rand_byte();
          last = (k == flen - 1);
          if ($urandom_range(0, 9) == 0) last = 1'($urandom);
          send_byte(b, last);
          sent++;
          // Pause mid-stream until the output has caught up
          if (p == 5 && sent == BytesPerPhase / 2) drain();
        end
      end
    end

    drain();
    repeat (SettleCycles) @(negedge clk_i);
    if (fail_count == 0 && chips_pending == 0) begin
      $display("uart_frame_line_encoder_core: match");
    end else begin
      $display("uart_frame_line_encoder_core: mismatch");
    end
    $finish;
  end

endmodule
